@@ hw/rtl/dfq_pkg.sv @@
package dfq_pkg;

  // Queue geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 16;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Field widths on the channels
  localparam int OP_W     = 2;
  localparam int VALUE_W  = 16;
  localparam int STATUS_W = 3;
  localparam int FILL_W   = 5;

  typedef logic [OP_W-1:0]       op_t;
  typedef logic [VALUE_W-1:0]    value_t;
  typedef logic [STATUS_W-1:0]   status_t;
  typedef logic [FILL_W-1:0]     fill_t;
  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // Command codes; any other code acts as flush
  localparam op_t OP_ENQ   = 2'd0;
  localparam op_t OP_DEQ   = 2'd1;
  localparam op_t OP_FLUSH = 2'd2;

  // Result codes
  localparam status_t ST_ENQ   = 3'd0;
  localparam status_t ST_DUP   = 3'd1;
  localparam status_t ST_FULL  = 3'd2;
  localparam status_t ST_DEQ   = 3'd3;
  localparam status_t ST_EMPTY = 3'd4;
  localparam status_t ST_FLUSH = 3'd5;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic enq;    // successful enqueue this cycle
    logic deq;    // successful dequeue this cycle, chain shifts to head
    logic flush;  // drop all entries
  } cell_ctrl_t;

endpackage

@@ hw/rtl/dfq_req_if.sv @@
interface dfq_req_if;
  logic           valid;
  logic           ready;
  dfq_pkg::op_t    op;
  dfq_pkg::value_t value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

@@ hw/rtl/dfq_rsp_if.sv @@
interface dfq_rsp_if;
  logic             valid;
  logic             ready;
  dfq_pkg::status_t status;
  dfq_pkg::value_t  out_value;
  dfq_pkg::fill_t   fill_count;

  modport source (output valid, output status, output out_value, output fill_count,
                  input ready);
  modport sink   (input valid, input status, input out_value, input fill_count,
                  output ready);
endinterface

@@ hw/rtl/dedup_fifo_queue.sv @@
// A result is registered and presented in the cycle after its request is accepted.
// Throughput: one request per cycle while each result is taken as it appears;
// the chain of cells compares combinationally and shifts as a request is taken, and a result still
// waiting in the output register holds off the next request until it is taken.
// Reset (rst, synchronous) empties the queue and drops any pending result;
// stored words are not cleared.
module dedup_fifo_queue (
  input  logic      clk,
  input  logic      rst,
  dfq_req_if.sink   req,
  dfq_rsp_if.source rsp
);
  import dfq_pkg::*;

  logic [DEPTH-1:0] valid_vec;
  logic [DEPTH-1:0] match_vec;
  data_t            data_arr [DEPTH];
  cell_ctrl_t       ctrl;
  cnt_t             count;
  cnt_t             count_next;
  logic             in_acc;
  logic             is_enq;
  logic             is_deq;
  logic             is_flush;
  logic             dup;
  logic             full;
  logic             empty;
  data_t            in_data;
  status_t          status_next;
  value_t           out_value_next;

  // Accept when the result register is free or being emptied
  assign req.ready = !rsp.valid || rsp.ready;
  assign in_acc    = req.valid && req.ready;

  // Decode the request
  assign in_data  = req.value[DATA_WIDTH-1:0];
  assign is_enq   = (req.op == OP_ENQ);
  assign is_deq   = (req.op == OP_DEQ);
  assign is_flush = !is_enq && !is_deq;
  assign dup      = |match_vec;
  assign full     = (count == cnt_t'(DEPTH));
  assign empty    = (count == '0);

  assign ctrl.enq   = in_acc && is_enq && !dup && !full;
  assign ctrl.deq   = in_acc && is_deq && !empty;
  assign ctrl.flush = in_acc && is_flush;

  // Chain of cells, oldest entry in cell zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic  prev_v;
    logic  next_v;
    data_t next_d;

    if (i == 0) begin : g_first
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_v = valid_vec[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_v = 1'b0;
      assign next_d = '0;
    end else begin : g_inner
      assign next_v = valid_vec[i+1];
      assign next_d = data_arr[i+1];
    end

    dfq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .value      (in_data),
      .prev_valid (prev_v),
      .next_valid (next_v),
      .next_data  (next_d),
      .valid      (valid_vec[i]),
      .data       (data_arr[i]),
      .match      (match_vec[i])
    );
  end

  // Work out status, returned word and new fill level
  always_comb begin
    status_next    = ST_FLUSH;
    out_value_next = '0;
    count_next     = count;
    if (is_flush) begin
      status_next = ST_FLUSH;
      count_next  = '0;
    end else if (is_enq) begin
      if (dup) begin
        status_next = ST_DUP;
      end else if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_ENQ;
        count_next  = cnt_t'(count + 1'b1);
      end
    end else begin
      if (empty) begin
        status_next = ST_EMPTY;
      end else begin
        status_next    = ST_DEQ;
        out_value_next = value_t'(data_arr[0]);
        count_next     = cnt_t'(count - 1'b1);
      end
    end
  end

  // Advance the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_acc) begin
      count <= count_next;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (in_acc) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rsp.status     <= status_next;
      rsp.out_value  <= out_value_next;
      rsp.fill_count <= fill_t'(count_next);
    end
  end

  // Fill level agrees with the occupied cells
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    count == cnt_t'($countones(valid_vec)))
    else $error("fill level does not match occupied cells");

  // Occupied cells form an unbroken run from the head
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & DEPTH'(valid_vec + 1'b1)) == '0)
    else $error("gap in the chain of occupied cells");

  // A flush leaves every cell empty
  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    ctrl.flush |=> (valid_vec == '0))
    else $error("cells still occupied after flush");

  // A returned word is reported together with the reduced fill level
  a_deq_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.deq |=> (rsp.valid && rsp.status == ST_DEQ && count == cnt_t'($past(count) - 1'b1)))
    else $error("dequeue result inconsistent with fill level");

endmodule

@@ hw/rtl/dfq_cell.sv @@
module dfq_cell (
  input  logic                clk,
  input  logic                rst,
  input  dfq_pkg::cell_ctrl_t ctrl,
  input  dfq_pkg::data_t      value,
  input  logic                prev_valid,
  input  logic                next_valid,
  input  dfq_pkg::data_t      next_data,
  output logic                valid,
  output dfq_pkg::data_t      data,
  output logic                match
);
  import dfq_pkg::*;

  logic load;

  // Take the new word when this is the first free cell
  assign load = ctrl.enq && !valid && prev_valid;

  // Hold, shift from the neighbour, or load the new word
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.flush) begin
      valid <= 1'b0;
    end else if (ctrl.deq) begin
      valid <= next_valid;
    end else if (load) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.deq) begin
      data <= next_data;
    end else if (load) begin
      data <= value;
    end
  end

  // Local duplicate compare
  assign match = valid && (data == value);

endmodule
